/* sv/julian_day_to_calendar_date_core_macros.svh */
// Assertion macros shared by the Julian date converter RTL.
// Define ASSERT_OFF to compile every assertion away.
`ifndef JULIAN_DAY_TO_CALENDAR_DATE_CORE_MACROS_SVH
`define JULIAN_DAY_TO_CALENDAR_DATE_CORE_MACROS_SVH
`ifndef ASSERT_OFF
// Concurrent check on the rising clock edge, switched off while reset is high.
`define JDCAL_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);
// Concurrent check on the rising clock edge that also holds during reset.
`define JDCAL_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define JDCAL_ASSERT(label, clk, rst, prop, msg)
`define JDCAL_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

/* sv/jdcal_pkg.sv */
// Shared types and constants of the Julian date to calendar date converter.
// Used by jdcal_date, jdcal_tod and julian_day_to_calendar_date_core; no dependencies.
`default_nettype none

package jdcal_pkg;

   // Day number width of the input and the civil day number after the half-day carry.
   localparam int DAY_BITS = 23;
   localparam int JD_BITS  = DAY_BITS + 1;
   localparam int A_BITS   = JD_BITS - 1;
   localparam int YEAR_CNT_BITS = 15;
   localparam int MODE_BITS = 2;

   typedef enum logic [MODE_BITS-1:0] {
      CAL_JULIAN    = 2'd0,
      CAL_AUTO      = 2'd1,
      CAL_GREGORIAN = 2'd2
   } cal_mode_type;

   // Calendar constants.
   localparam int JULIAN_LAST_DAY  = 2299160;
   localparam int GREG_BASE_DAY    = 1721119;
   localparam int GREG_NUM_OFFSET  = 365;
   localparam int JUL_NUM_OFFSET   = 105498;
   localparam int JUL_DY_OFFSET    = 105133;
   localparam int JUL_YEAR_OFFSET  = 5000;
   localparam int DAYS_400Y        = 146097;
   localparam int DAYS_4Y          = 1461;
   localparam int DAYS_PER_YEAR    = 365;
   localparam int YEARS_PER_CENT   = 100;
   localparam int DAYS_5MONTHS     = 153;
   localparam int MONTH_WRAP       = 10;
   localparam int MONTH_FROM_MARCH = 3;
   localparam int MONTH_BACK       = 9;

   // Reciprocals for division by constants; each estimate is low by at most one.
   localparam int C_SHIFT  = 25;
   localparam int C_RECIP  = (1 << C_SHIFT) / DAYS_400Y;
   localparam int Y_SHIFT  = 26;
   localparam int Y_RECIP  = (1 << Y_SHIFT) / DAYS_4Y;
   localparam int H_SHIFT  = 15;
   localparam int H_RECIP  = (1 << H_SHIFT) / YEARS_PER_CENT;
   localparam int M_SHIFT  = 11;
   localparam int M_RECIP  = (1 << M_SHIFT) / DAYS_5MONTHS;
   localparam int D5_SHIFT = 10;
   localparam int D5_RECIP = (1 << D5_SHIFT) / 5 + 1;

   // Pipeline depths.
   localparam int DATE_STAGES = 9;
   localparam int TOD_STAGES  = 3;
   localparam int F_DELAY     = DATE_STAGES - TOD_STAGES;
   localparam int PIPE_DEPTH  = DATE_STAGES + 1;

   typedef struct packed {
      logic [DAY_BITS-1:0] jd_whole;
      logic [31:0]         jd_fraction;
   } jdcal_req_type;

   typedef struct packed {
      logic [4:0]         day_of_month;
      logic [3:0]         month;
      logic signed [15:0] year;
      logic [4:0]         hour;
      logic [5:0]         minute;
      logic [5:0]         second;
      logic [31:0]        second_fraction;
      logic               out_of_range;
   } jdcal_rsp_type;

   typedef struct packed {
      logic [4:0]         day_of_month;
      logic [3:0]         month;
      logic signed [15:0] year;
      logic               out_of_range;
   } date_type;

   typedef struct packed {
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [31:0] second_fraction;
   } tod_type;

endpackage

`default_nettype wire

/* sv/julian_day_to_calendar_date_core.sv */
// Julian date to calendar date and time of day. A transaction carries a Julian date as
// whole days plus an unsigned Q0.32 day fraction, both counted from noon; it is taken on
// any rising clock edge where start is high, and busy is never raised, so one transaction
// can enter in every cycle. Each result appears on rsp_payload for exactly one cycle,
// marked by rsp_strobe, after one input stage and the nine-stage date pipeline, whose
// length is set by the divisions by constants (all but the last, by five, are a reciprocal
// multiply followed by a one-step correction in the next stage). The receiver
// cannot stall and needs no flow control: results come out in order, one per cycle at most.
// The csr_wdata register selects the calendar: 0 Julian, 1 automatic (Julian through
// 1582 October 4, Gregorian after), 2 or 3 Gregorian; it resets to automatic and should only
// be written while no transaction is in flight. For a Gregorian date at or before the
// Gregorian base day, out_of_range is set and day, month and year read as zero, while the
// time fields stay valid. Depends on jdcal_pkg, jdcal_date, jdcal_tod and the macro header.
`default_nettype none
`include "julian_day_to_calendar_date_core_macros.svh"

module julian_day_to_calendar_date_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  jdcal_pkg::jdcal_req_type             req_payload,
   output logic                                 rsp_strobe,
   output jdcal_pkg::jdcal_rsp_type             rsp_payload,
   input  logic                                 csr_we,
   input  logic [jdcal_pkg::MODE_BITS-1:0]      csr_wdata
);
   import jdcal_pkg::*;

   // The pipeline never stalls, so a new transaction is always welcome.
   assign busy = 1'b0;

   logic req_accept;
   assign req_accept = start && !busy;

   // Calendar mode register.
   logic [MODE_BITS-1:0] mode_ff;
   logic [MODE_BITS-1:0] mode_in;

   // Valid bits that travel alongside the data through every stage.
   logic [PIPE_DEPTH-1:0] vld_ff;
   logic [PIPE_DEPTH-1:0] vld_in;

   always_comb begin
      mode_in = csr_we ? csr_wdata : mode_ff;
      vld_in  = {vld_ff[PIPE_DEPTH-2:0], req_accept};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= CAL_AUTO;
         vld_ff  <= '0;
      end else begin
         mode_ff <= mode_in;
         vld_ff  <= vld_in;
      end
   end

   // Input stage: adding half a day moves the day boundary from noon to midnight.
   // The carry out of the fraction is its top bit, and the new fraction has that bit flipped.
   logic [JD_BITS-1:0] j_in;
   logic [31:0]        f_in;
   logic [JD_BITS-1:0] j1_ff;
   logic [31:0]        f1_ff;

   always_comb begin
      j_in = JD_BITS'(req_payload.jd_whole) + JD_BITS'(req_payload.jd_fraction[31]);
      f_in = {~req_payload.jd_fraction[31], req_payload.jd_fraction[30:0]};
   end

   always_ff @(posedge clock) begin
      j1_ff <= j_in;
      f1_ff <= f_in;
   end

   // The time scaler is shorter than the date pipeline, so the fraction waits in a
   // delay line until both halves of a result leave on the same cycle.
   logic [31:0] f_dly_ff [F_DELAY];

   always_ff @(posedge clock) begin
      f_dly_ff[0] <= f1_ff;
      for (int i = 1; i < F_DELAY; i++) begin
         f_dly_ff[i] <= f_dly_ff[i-1];
      end
   end

   date_type date;
   tod_type  tod;

   jdcal_date u_date (
      .clock    (clock),
      .day_num  (j1_ff),
      .cal_mode (mode_ff),
      .date     (date)
   );

   jdcal_tod u_tod (
      .clock    (clock),
      .day_frac (f_dly_ff[F_DELAY-1]),
      .tod      (tod)
   );

   // Both units end in registers, so the result ports come straight from flops.
   always_comb begin
      rsp_payload.day_of_month    = date.day_of_month;
      rsp_payload.month           = date.month;
      rsp_payload.year            = date.year;
      rsp_payload.hour            = tod.hour;
      rsp_payload.minute          = tod.minute;
      rsp_payload.second          = tod.second;
      rsp_payload.second_fraction = tod.second_fraction;
      rsp_payload.out_of_range    = date.out_of_range;
   end

   assign rsp_strobe = vld_ff[PIPE_DEPTH-1];

   // Every accepted transaction yields its result after the fixed latency, and only then.
   `JDCAL_ASSERT(a_result_follows, clock, reset, req_accept |-> ##PIPE_DEPTH rsp_strobe, "accepted transaction produced no result at the expected cycle")
   `JDCAL_ASSERT(a_result_has_source, clock, reset, rsp_strobe |-> $past(req_accept, PIPE_DEPTH), "result strobe without a matching transaction")
   `JDCAL_ASSERT_ALWAYS(a_quiet_after_reset, clock, reset |=> !rsp_strobe, "result strobe right after reset")
   `JDCAL_ASSERT(a_range_zeroes_date, clock, reset, (rsp_strobe && rsp_payload.out_of_range) |-> (rsp_payload.day_of_month == 5'd0 && rsp_payload.month == 4'd0 && rsp_payload.year == 16'sd0), "out-of-range result carries a date")
   `JDCAL_ASSERT(a_date_legal, clock, reset, (rsp_strobe && !rsp_payload.out_of_range) |-> (rsp_payload.month >= 4'd1 && rsp_payload.month <= 4'd12 && rsp_payload.day_of_month != 5'd0), "in-range result has an impossible month or day")

endmodule

`default_nettype wire

/* sv/jdcal_date.sv */
// Nine-stage pipeline from civil day number to day, month, year and range flag.
// Depends on jdcal_pkg.
`default_nettype none

module jdcal_date (
   input  logic                          clock,
   input  logic [jdcal_pkg::JD_BITS-1:0] day_num,
   input  logic [jdcal_pkg::MODE_BITS-1:0] cal_mode,
   output jdcal_pkg::date_type           date
);
   import jdcal_pkg::*;

   // Stage 1: calendar choice, days since the Gregorian base, 400-year estimate.
   logic                  gr_in;
   logic                  bad_in;
   logic [JD_BITS-1:0]    j_minus_base;
   logic [A_BITS-1:0]     a_in;
   logic [C_SHIFT-1:0]    x4a_in;
   logic [C_SHIFT+7:0]    pc_in;
   logic [JD_BITS-1:0]    j_d1_ff;
   logic [A_BITS-1:0]     a_d1_ff;
   logic                  gr_d1_ff, bad_d1_ff;
   logic [7:0]            q0c_d1_ff;

   always_comb begin
      case (cal_mode)
         CAL_JULIAN: gr_in = 1'b0;
         CAL_AUTO:   gr_in = (day_num > JD_BITS'(JULIAN_LAST_DAY));
         default:    gr_in = 1'b1;
      endcase
      bad_in       = gr_in && (day_num <= JD_BITS'(GREG_BASE_DAY));
      j_minus_base = day_num - JD_BITS'(GREG_BASE_DAY);
      a_in         = (day_num > JD_BITS'(GREG_BASE_DAY)) ? j_minus_base[A_BITS-1:0] : '0;
      x4a_in       = {a_in, 2'b00};
      pc_in        = x4a_in * 8'(C_RECIP);
   end

   always_ff @(posedge clock) begin
      j_d1_ff   <= day_num;
      a_d1_ff   <= a_in;
      gr_d1_ff  <= gr_in;
      bad_d1_ff <= bad_in;
      q0c_d1_ff <= pc_in[C_SHIFT +: 8];
   end

   // Stage 2: correct the 400-year count and form the century term.
   logic [C_SHIFT-1:0] x4a_d1;
   logic [C_SHIFT-1:0] rem_c;
   logic [7:0]         c_in;
   logic [9:0]         c3_in;
   logic [7:0]         t_in;
   logic [JD_BITS-1:0] j_d2_ff;
   logic [A_BITS-1:0]  a_d2_ff;
   logic               gr_d2_ff, bad_d2_ff;
   logic [7:0]         t_d2_ff;

   always_comb begin
      x4a_d1 = {a_d1_ff, 2'b00};
      rem_c  = x4a_d1 - C_SHIFT'(q0c_d1_ff * DAYS_400Y);
      c_in   = q0c_d1_ff + 8'(rem_c >= C_SHIFT'(DAYS_400Y));
      c3_in  = (10'(c_in) + 10'd1) * 10'd3;
      t_in   = c3_in[9:2];
   end

   always_ff @(posedge clock) begin
      j_d2_ff   <= j_d1_ff;
      a_d2_ff   <= a_d1_ff;
      gr_d2_ff  <= gr_d1_ff;
      bad_d2_ff <= bad_d1_ff;
      t_d2_ff   <= t_in;
   end

   // Stage 3: numerator of the year formula and the four-year estimate.
   logic [JD_BITS-1:0]       b_in;
   logic [Y_SHIFT-1:0]       n_in;
   logic [Y_SHIFT+15:0]      py_in;
   logic [Y_SHIFT-1:0]       n_d3_ff;
   logic [YEAR_CNT_BITS-1:0] q0y_d3_ff;
   logic [JD_BITS-1:0]       j_d3_ff;
   logic [A_BITS-1:0]        a_d3_ff;
   logic                     gr_d3_ff, bad_d3_ff;

   always_comb begin
      if (gr_d2_ff) begin
         b_in = JD_BITS'(a_d2_ff) + JD_BITS'(GREG_NUM_OFFSET) + JD_BITS'(t_d2_ff);
      end else begin
         b_in = j_d2_ff + JD_BITS'(JUL_NUM_OFFSET);
      end
      n_in  = {b_in, 2'b00};
      py_in = n_in * 16'(Y_RECIP);
   end

   always_ff @(posedge clock) begin
      n_d3_ff   <= n_in;
      q0y_d3_ff <= py_in[Y_SHIFT +: YEAR_CNT_BITS];
      j_d3_ff   <= j_d2_ff;
      a_d3_ff   <= a_d2_ff;
      gr_d3_ff  <= gr_d2_ff;
      bad_d3_ff <= bad_d2_ff;
   end

   // Stage 4: corrected year count and the base of the day-of-year sum.
   logic [Y_SHIFT-1:0]       rem_y;
   logic [YEAR_CNT_BITS-1:0] y1_in;
   logic [JD_BITS-1:0]       dbase_in;
   logic [YEAR_CNT_BITS-1:0] yp_d4_ff;
   logic [JD_BITS-1:0]       dbase_d4_ff;
   logic                     gr_d4_ff, bad_d4_ff;

   always_comb begin
      rem_y    = n_d3_ff - Y_SHIFT'(q0y_d3_ff * DAYS_4Y);
      y1_in    = q0y_d3_ff + YEAR_CNT_BITS'(rem_y >= Y_SHIFT'(DAYS_4Y));
      dbase_in = gr_d3_ff ? JD_BITS'(a_d3_ff) : (j_d3_ff + JD_BITS'(JUL_DY_OFFSET));
   end

   always_ff @(posedge clock) begin
      yp_d4_ff    <= y1_in - YEAR_CNT_BITS'(1);
      dbase_d4_ff <= dbase_in;
      gr_d4_ff    <= gr_d3_ff;
      bad_d4_ff   <= bad_d3_ff;
   end

   // Stage 5: days in the whole years, and the century count estimate.
   logic [JD_BITS-1:0]       k_in;
   logic [YEAR_CNT_BITS+8:0] ph_in;
   logic [YEAR_CNT_BITS-1:0] yp_d5_ff;
   logic [JD_BITS-1:0]       k_d5_ff;
   logic [7:0]               q0h_d5_ff;
   logic [JD_BITS-1:0]       dbase_d5_ff;
   logic                     gr_d5_ff, bad_d5_ff;

   always_comb begin
      k_in  = JD_BITS'(yp_d4_ff * DAYS_PER_YEAR) + JD_BITS'(yp_d4_ff >> 2);
      ph_in = yp_d4_ff * 9'(H_RECIP);
   end

   always_ff @(posedge clock) begin
      yp_d5_ff    <= yp_d4_ff;
      k_d5_ff     <= k_in;
      q0h_d5_ff   <= ph_in[H_SHIFT +: 8];
      dbase_d5_ff <= dbase_d4_ff;
      gr_d5_ff    <= gr_d4_ff;
      bad_d5_ff   <= bad_d4_ff;
   end

   // Stage 6: century correction, day of the year counted from March, and year.
   logic [YEAR_CNT_BITS-1:0] rem_h;
   logic [7:0]               h_in;
   logic [9:0]               gm_in;
   logic [7:0]               g_in;
   logic [JD_BITS-1:0]       dy_full;
   logic [15:0]              yr_in;
   logic [8:0]               dy_d6_ff;
   logic [15:0]              yr_d6_ff;
   logic                     bad_d6_ff;

   always_comb begin
      rem_h   = yp_d5_ff - YEAR_CNT_BITS'(q0h_d5_ff * YEARS_PER_CENT);
      h_in    = q0h_d5_ff + 8'(rem_h >= YEAR_CNT_BITS'(YEARS_PER_CENT));
      gm_in   = (10'(h_in) + 10'd1) * 10'd3;
      g_in    = gr_d5_ff ? gm_in[9:2] : '0;
      dy_full = dbase_d5_ff - k_d5_ff + JD_BITS'(g_in);
      if (gr_d5_ff) begin
         yr_in = 16'(yp_d5_ff);
      end else begin
         yr_in = 16'(yp_d5_ff) - 16'(JUL_YEAR_OFFSET);
      end
   end

   always_ff @(posedge clock) begin
      dy_d6_ff  <= dy_full[8:0];
      yr_d6_ff  <= yr_in;
      bad_d6_ff <= bad_d5_ff;
   end

   // Stage 7: month estimate from the day of the year.
   logic [10:0] x_in;
   logic [14:0] pm_in;
   logic [10:0] x_d7_ff;
   logic [3:0]  q0m_d7_ff;
   logic [15:0] yr_d7_ff;
   logic        bad_d7_ff;

   always_comb begin
      x_in  = 11'(dy_d6_ff * 5) - 11'd3;
      pm_in = x_in * 4'(M_RECIP);
   end

   always_ff @(posedge clock) begin
      x_d7_ff   <= x_in;
      q0m_d7_ff <= pm_in[M_SHIFT +: 4];
      yr_d7_ff  <= yr_d6_ff;
      bad_d7_ff <= bad_d6_ff;
   end

   // Stage 8: month correction and the remainder that carries the day.
   logic [10:0] rem_m;
   logic [10:0] rem_m_sub;
   logic [3:0]  mp_in;
   logic [7:0]  r_in;
   logic [3:0]  mp_d8_ff;
   logic [7:0]  r_d8_ff;
   logic [15:0] yr_d8_ff;
   logic        bad_d8_ff;

   always_comb begin
      rem_m     = x_d7_ff - 11'(q0m_d7_ff * DAYS_5MONTHS);
      rem_m_sub = rem_m - 11'(DAYS_5MONTHS);
      if (rem_m >= 11'(DAYS_5MONTHS)) begin
         mp_in = q0m_d7_ff + 4'd1;
         r_in  = rem_m_sub[7:0];
      end else begin
         mp_in = q0m_d7_ff;
         r_in  = rem_m[7:0];
      end
   end

   always_ff @(posedge clock) begin
      mp_d8_ff  <= mp_in;
      r_d8_ff   <= r_in;
      yr_d8_ff  <= yr_d7_ff;
      bad_d8_ff <= bad_d7_ff;
   end

   // Stage 9: day of the month, month numbered from January, year carry.
   logic [15:0] pd_in;
   date_type    date_in;
   date_type    date_ff;

   always_comb begin
      pd_in = r_d8_ff * 8'(D5_RECIP);
      date_in.day_of_month = pd_in[D5_SHIFT +: 5] + 5'd1;
      if (mp_d8_ff >= 4'(MONTH_WRAP)) begin
         date_in.month = mp_d8_ff - 4'(MONTH_BACK);
         date_in.year  = yr_d8_ff + 16'd1;
      end else begin
         date_in.month = mp_d8_ff + 4'(MONTH_FROM_MARCH);
         date_in.year  = yr_d8_ff;
      end
      date_in.out_of_range = bad_d8_ff;
      if (bad_d8_ff) begin
         date_in.day_of_month = '0;
         date_in.month        = '0;
         date_in.year         = '0;
      end
   end

   always_ff @(posedge clock) begin
      date_ff <= date_in;
   end

   assign date = date_ff;

endmodule

`default_nettype wire

/* sv/jdcal_tod.sv */
// Three-stage time-of-day scaler: Q0.32 day fraction to hour, minute, second and second fraction.
// Depends on jdcal_pkg.
`default_nettype none

module jdcal_tod (
   input  logic               clock,
   input  logic [31:0]        day_frac,
   output jdcal_pkg::tod_type tod
);
   import jdcal_pkg::*;

   logic [36:0] p1_in;
   logic [4:0]  hour_t1_ff;
   logic [31:0] r1_t1_ff;

   logic [37:0] p2_in;
   logic [4:0]  hour_t2_ff;
   logic [5:0]  minute_t2_ff;
   logic [31:0] r2_t2_ff;

   logic [37:0] p3_in;
   tod_type     tod_in;
   tod_type     tod_ff;

   // Each stage keeps the integer part of one scaling and passes the exact low bits on.
   always_comb begin
      p1_in = day_frac * 5'd24;
      p2_in = r1_t1_ff * 6'd60;
      p3_in = r2_t2_ff * 6'd60;
      tod_in.hour            = hour_t2_ff;
      tod_in.minute          = minute_t2_ff;
      tod_in.second          = p3_in[37:32];
      tod_in.second_fraction = p3_in[31:0];
   end

   always_ff @(posedge clock) begin
      hour_t1_ff   <= p1_in[36:32];
      r1_t1_ff     <= p1_in[31:0];
      hour_t2_ff   <= hour_t1_ff;
      minute_t2_ff <= p2_in[37:32];
      r2_t2_ff     <= p2_in[31:0];
      tod_ff       <= tod_in;
   end

   assign tod = tod_ff;

endmodule

`default_nettype wire
